// File: design/ascii_set_command_output_module_defines.svh
// assertion macros for the ascii set command decoder
// used by the port checker; expects clk and rst_n in the including scope
`ifndef ASCII_SET_COMMAND_OUTPUT_MODULE_DEFINES_SVH
`define ASCII_SET_COMMAND_OUTPUT_MODULE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define ASCMD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ascmd port check failed");

// next-cycle implication, disabled while reset is low
`define ASCMD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ascmd port check failed");

`endif

// File: design/ascmd_pkg.sv
// shared types, codes and character constants of the ascii set command decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ascmd_pkg;

    localparam int NUM_OUTPUTS = 8;
    localparam int PIN_W       = 8;

    localparam logic [3:0] MODULE_ID_RESET = 4'd1;

    // input beat kinds
    typedef enum logic [1:0] {
        MODE_BYTE = 2'd0,
        MODE_END  = 2'd1,
        MODE_READ = 2'd2
    } mode_t;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_X     = 8'h58;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take_byte;
        logic end_write;
        logic start_reply;
        logic load_eow;
        logic load_reply;
    } ascmd_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic slot_free;
        logic reply_at_last;
    } ascmd_sts_t;

    // "/SET." frame head, position 0 to 4
    function automatic logic [7:0] frame_head_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = CH_SLASH;
            3'd1:    c = CH_S;
            3'd2:    c = CH_E;
            3'd3:    c = CH_T;
            default: c = CH_DOT;
        endcase
        return c;
    endfunction

    // "DONE" or "XXXX"
    function automatic logic [7:0] word_char(input logic done, input logic [1:0] pos);
        logic [7:0] c;
        if (!done)
        begin
            c = CH_X;
        end
        else
        begin
            unique case (pos)
                2'd0:    c = 8'h44;
                2'd1:    c = 8'h4F;
                2'd2:    c = 8'h4E;
                default: c = 8'h45;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/ascmd_in_if.sv
// input channel: write bytes, end of write and read requests
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ascmd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

`default_nettype wire

// File: design/ascmd_out_if.sv
// output channel: reply bytes and end-of-write results
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ascmd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] reply_byte;
    logic       reply_last;
    logic [7:0] output_pins;
    logic       command_done;

    modport source (output valid, output reply_byte, output reply_last,
                    output output_pins, output command_done, input ready);
    modport sink   (input valid, input reply_byte, input reply_last,
                    input output_pins, input command_done, output ready);
endinterface

`default_nettype wire

// File: design/ascmd_cfg_if.sv
// configuration write channel carrying the module id
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface ascmd_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] module_id;

    modport source (output valid, output module_id, input ready);
    modport sink   (input valid, input module_id, output ready);
endinterface

`default_nettype wire

// File: design/ascmd_ctrl.sv
// controller state machine: accepts input beats and sequences result beats
// depends on ascmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ascmd_ctrl
    import ascmd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [1:0] in_mode,
    output logic            in_ready,
    input  wire ascmd_sts_t sts,
    output ascmd_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EOW   = 3'b010,
        ST_REPLY = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    mode_t  mode;

    assign mode = mode_t'(in_mode);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (mode)
                        MODE_BYTE:
                        begin
                            cmd.take_byte = 1'b1;
                        end
                        MODE_END:
                        begin
                            cmd.end_write = 1'b1;
                            state_next    = ST_EOW;
                        end
                        MODE_READ:
                        begin
                            cmd.start_reply = 1'b1;
                            state_next      = ST_REPLY;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EOW:
            begin
                if (sts.slot_free)
                begin
                    cmd.load_eow = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_REPLY:
            begin
                if (sts.slot_free)
                begin
                    cmd.load_reply = 1'b1;
                    if (sts.reply_at_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: design/ascmd_dp.sv
// datapath: frame matching, command commit, pin levels, reply text and output register
// depends on ascmd_pkg
`timescale 1ns / 1ps
`default_nettype none

module ascmd_dp
    import ascmd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ascmd_cmd_t cmd,
    output ascmd_sts_t      sts,
    input  wire logic [7:0] data_byte,
    input  wire logic       cfg_write,
    input  wire logic [3:0] cfg_module_id,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic [7:0]      out_reply_byte,
    output logic            out_reply_last,
    output logic [7:0]      out_output_pins,
    output logic            out_command_done
);

    // frame tracking
    logic [3:0]       byte_pos_reg;
    logic [3:0]       byte_pos_next;
    logic             prefix_ok_reg;
    logic             prefix_ok_next;
    logic             frame_ok_reg;
    logic             frame_ok_next;
    logic [1:0]       pend_len_reg;
    logic [1:0]       pend_len_next;
    logic [7:0]       pend_chars_reg [2];
    logic [7:0]       value_chars_reg [4];

    // committed state
    logic [3:0]       module_id_reg;
    logic [7:0]       num_chars_reg [2];
    logic [1:0]       num_len_reg;
    logic [PIN_W-1:0] pins_reg;
    logic [PIN_W-1:0] pins_next;
    logic             done_reg;
    logic             done_next;
    logic             done_snap_reg;
    logic [3:0]       idx_reg;

    // output register
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    logic [PIN_W-1:0] out_pins_reg;
    logic             out_done_reg;

    logic             commit_num;
    logic             cmd_ok;
    logic             val_ok;
    logic             val_nz;
    logic [7:0]       pin_off;
    logic [7:0]       reply_char;
    logic             reply_last;
    logic [3:0]       len_ext;

    // atol over the four value characters: accept flag and nonzero flag
    function automatic logic [1:0] value_check(input logic [7:0] c0, input logic [7:0] c1,
                                               input logic [7:0] c2, input logic [7:0] c3);
        logic [7:0] ch [4];
        logic [1:0] phase;
        logic       neg;
        logic       nz;
        logic       gt1;
        logic       dig;
        ch[0] = c0;
        ch[1] = c1;
        ch[2] = c2;
        ch[3] = c3;
        phase = 2'd0;
        neg   = 1'b0;
        nz    = 1'b0;
        gt1   = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            dig = (ch[i] >= CH_ZERO) && (ch[i] <= CH_NINE);
            if (phase == 2'd0)
            begin
                if (ch[i] == CH_SPACE || (ch[i] >= 8'd9 && ch[i] <= 8'd13))
                begin
                    phase = 2'd0;
                end
                else if (ch[i] == CH_PLUS || ch[i] == CH_MINUS)
                begin
                    neg   = (ch[i] == CH_MINUS);
                    phase = 2'd1;
                end
                else if (dig)
                begin
                    gt1   = gt1 | nz | (ch[i] >= CH_ZERO + 8'd2);
                    nz    = nz | (ch[i] != CH_ZERO);
                    phase = 2'd1;
                end
                else
                begin
                    phase = 2'd2;
                end
            end
            else if (phase == 2'd1)
            begin
                if (dig)
                begin
                    gt1 = gt1 | nz | (ch[i] >= CH_ZERO + 8'd2);
                    nz  = nz | (ch[i] != CH_ZERO);
                end
                else
                begin
                    phase = 2'd2;
                end
            end
        end
        return {neg | ~gt1, nz};
    endfunction

    assign {val_ok, val_nz} = value_check(value_chars_reg[0], value_chars_reg[1],
                                          value_chars_reg[2], value_chars_reg[3]);

    // frame matching on each write byte
    always_comb
    begin
        byte_pos_next  = byte_pos_reg;
        prefix_ok_next = prefix_ok_reg;
        frame_ok_next  = frame_ok_reg;
        pend_len_next  = pend_len_reg;
        if (cmd.take_byte && byte_pos_reg != 4'd15)
        begin
            byte_pos_next = byte_pos_reg + 4'd1;
            if (byte_pos_reg < 4'd5)
            begin
                if (data_byte != frame_head_char(byte_pos_reg[2:0]))
                begin
                    prefix_ok_next = 1'b0;
                end
            end
            else if (byte_pos_reg == 4'd5)
            begin
                if (module_id_reg > 4'd9 || data_byte != CH_ZERO + {4'd0, module_id_reg})
                begin
                    prefix_ok_next = 1'b0;
                end
            end
            else if (byte_pos_reg == 4'd6)
            begin
                if (data_byte != CH_DOT)
                begin
                    prefix_ok_next = 1'b0;
                end
            end
            else if (byte_pos_reg <= 4'd8)
            begin
                pend_len_next = 2'(byte_pos_reg - 4'd6);
            end
            else if (byte_pos_reg == 4'd9)
            begin
                if (data_byte != CH_EQ)
                begin
                    frame_ok_next = 1'b0;
                end
            end
            else if (byte_pos_reg == 4'd14)
            begin
                if (data_byte != CH_COLON)
                begin
                    frame_ok_next = 1'b0;
                end
            end
        end
        if (cmd.end_write)
        begin
            byte_pos_next  = 4'd0;
            prefix_ok_next = 1'b1;
            frame_ok_next  = 1'b1;
            pend_len_next  = 2'd0;
        end
    end

    // command commit at end of write
    assign commit_num = prefix_ok_reg && (byte_pos_reg >= 4'd7);
    assign cmd_ok     = commit_num && frame_ok_reg && (byte_pos_reg == 4'd15)
                        && (pend_chars_reg[0] == CH_ZERO)
                        && (pend_chars_reg[1] >= CH_ONE)
                        && (pend_chars_reg[1] <= CH_ZERO + 8'(NUM_OUTPUTS))
                        && val_ok;
    assign pin_off    = pend_chars_reg[1] - CH_ONE;

    always_comb
    begin
        pins_next = pins_reg;
        done_next = done_reg;
        if (cmd.end_write)
        begin
            done_next = cmd_ok;
            if (cmd_ok && pin_off < 8'(PIN_W))
            begin
                pins_next[pin_off[$clog2(PIN_W)-1:0]] = val_nz;
            end
        end
        if (cmd.start_reply)
        begin
            done_next = 1'b0;
        end
    end

    // reply text at the current index
    assign len_ext = {2'd0, num_len_reg};

    always_comb
    begin
        if (idx_reg == 4'd0)
        begin
            reply_char = CH_ZERO + {4'd0, module_id_reg};
        end
        else if (idx_reg == 4'd1)
        begin
            reply_char = CH_DOT;
        end
        else if (idx_reg < 4'd2 + len_ext)
        begin
            reply_char = num_chars_reg[1'(idx_reg - 4'd2)];
        end
        else if (idx_reg == 4'd2 + len_ext)
        begin
            reply_char = CH_DOT;
        end
        else if (idx_reg < 4'd7 + len_ext)
        begin
            reply_char = word_char(done_snap_reg, 2'(idx_reg - 4'd3 - len_ext));
        end
        else
        begin
            reply_char = CH_SEMI;
        end
    end

    assign reply_last = (idx_reg == 4'd7 + len_ext);

    // status back to the controller
    assign sts.slot_free     = !out_valid_reg || out_ready;
    assign sts.reply_at_last = reply_last;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg     <= 4'd0;
            prefix_ok_reg    <= 1'b1;
            frame_ok_reg     <= 1'b1;
            pend_len_reg     <= 2'd0;
            module_id_reg    <= MODULE_ID_RESET;
            num_chars_reg[0] <= CH_X;
            num_chars_reg[1] <= CH_X;
            num_len_reg      <= 2'd2;
            pins_reg         <= '0;
            done_reg         <= 1'b0;
            idx_reg          <= 4'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            byte_pos_reg  <= byte_pos_next;
            prefix_ok_reg <= prefix_ok_next;
            frame_ok_reg  <= frame_ok_next;
            pend_len_reg  <= pend_len_next;
            pins_reg      <= pins_next;
            done_reg      <= done_next;
            if (cfg_write)
            begin
                module_id_reg <= cfg_module_id;
            end
            if (cmd.end_write && commit_num)
            begin
                num_chars_reg[0] <= pend_chars_reg[0];
                num_chars_reg[1] <= pend_chars_reg[1];
                num_len_reg      <= pend_len_reg;
            end
            if (cmd.start_reply)
            begin
                idx_reg <= 4'd0;
            end
            else if (cmd.load_reply)
            begin
                idx_reg <= idx_reg + 4'd1;
            end
            if (cmd.load_eow || cmd.load_reply)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte && byte_pos_reg >= 4'd7 && byte_pos_reg <= 4'd8)
        begin
            pend_chars_reg[1'(byte_pos_reg - 4'd7)] <= data_byte;
        end
        if (cmd.take_byte && byte_pos_reg >= 4'd10 && byte_pos_reg <= 4'd13)
        begin
            value_chars_reg[2'(byte_pos_reg - 4'd10)] <= data_byte;
        end
        if (cmd.start_reply)
        begin
            done_snap_reg <= done_reg;
        end
        if (cmd.load_eow)
        begin
            out_byte_reg <= 8'd0;
            out_last_reg <= 1'b1;
            out_pins_reg <= pins_reg;
            out_done_reg <= done_reg;
        end
        else if (cmd.load_reply)
        begin
            out_byte_reg <= reply_char;
            out_last_reg <= reply_last;
            out_pins_reg <= pins_reg;
            out_done_reg <= done_snap_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_reply_byte   = out_byte_reg;
    assign out_reply_last   = out_last_reg;
    assign out_output_pins  = out_pins_reg;
    assign out_command_done = out_done_reg;

endmodule

`default_nettype wire

// File: design/ascii_set_command_output_module.sv
// write byte, end-of-write and read-request beats are taken only while the controller is idle.
// end-of-write result is loaded into the output register from the EOW state once the output slot is free.
// read request: 8 to 10 reply beats, one per cycle unless the output stalls; the next input is
// taken after the reply sequencer has loaded the last beat into the output register.
// asynchronous active-low reset: pins low, done clear, module id 1, reply number "XX".
// top level of the ascii set command decoder; depends on ascmd_pkg, interfaces, ctrl, dp
`timescale 1ns / 1ps
`default_nettype none

module ascii_set_command_output_module
    import ascmd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    ascmd_in_if.sink     cmd_in,
    ascmd_out_if.source  rsp_out,
    ascmd_cfg_if.sink    cfg
);

    ascmd_cmd_t cmd;
    ascmd_sts_t sts;

    // configuration is always taken
    assign cfg.ready = 1'b1;

    // controller
    ascmd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd_in.valid),
        .in_mode  (cmd_in.mode),
        .in_ready (cmd_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    ascmd_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .data_byte        (cmd_in.data_byte),
        .cfg_write        (cfg.valid),
        .cfg_module_id    (cfg.module_id),
        .out_ready        (rsp_out.ready),
        .out_valid        (rsp_out.valid),
        .out_reply_byte   (rsp_out.reply_byte),
        .out_reply_last   (rsp_out.reply_last),
        .out_output_pins  (rsp_out.output_pins),
        .out_command_done (rsp_out.command_done)
    );

endmodule

`default_nettype wire

// File: design/ascmd_checker.sv
// port checker for the ascii set command decoder, bound to the top level
// depends on ascmd_pkg and ascii_set_command_output_module_defines.svh
`timescale 1ns / 1ps
`default_nettype none

`include "ascii_set_command_output_module_defines.svh"

module ascmd_checker
    import ascmd_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [1:0] in_mode,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_reply_byte,
    input wire logic       out_reply_last
);

    // a stalled result beat stays valid
    `ASCMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // a stalled result beat keeps its text
    `ASCMD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready,
        $stable(out_reply_byte) && $stable(out_reply_last))

    // no input is taken in the middle of a reply
    `ASCMD_ASSERT_SAME(a_no_in_mid_reply, out_valid && !out_reply_last, !in_ready)

    // end of write or read request holds off input in the next cycle
    `ASCMD_ASSERT_NEXT(a_busy_after_req,
        in_valid && in_ready && (in_mode == MODE_END || in_mode == MODE_READ), !in_ready)

endmodule

bind ascii_set_command_output_module ascmd_checker u_ascmd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (cmd_in.valid),
    .in_ready       (cmd_in.ready),
    .in_mode        (cmd_in.mode),
    .out_valid      (rsp_out.valid),
    .out_ready      (rsp_out.ready),
    .out_reply_byte (rsp_out.reply_byte),
    .out_reply_last (rsp_out.reply_last)
);

`default_nettype wire

// File: verif/ascmd_command_checker.sv
// port monitor and scoreboard for the ascii set command decoder
// keeps its own decoder state, predicts every reply beat and compares it
// depends on ascmd_pkg and the ascmd_in_if, ascmd_out_if and ascmd_cfg_if interfaces
`timescale 1ns / 1ps

module ascmd_command_checker
    import ascmd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    ascmd_in_if       cmd_mon,
    ascmd_out_if      rsp_mon,
    ascmd_cfg_if      cfg_mon,
    output int        mismatches,
    output int        awaiting,
    output int        beats_checked
);

    localparam logic [7:0]  CH_TAB     = 8'h09;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [39:0] FRAME_HEAD = {CH_SLASH, CH_S, CH_E, CH_T, CH_DOT};
    localparam logic [31:0] WORD_DONE  = "DONE";
    localparam logic [31:0] WORD_FAIL  = "XXXX";

    typedef struct packed {
        logic [7:0] text;
        logic       last;
        logic [7:0] pins;
        logic       done;
    } reply_beat_t;

    reply_beat_t expected_replies[$];
    reply_beat_t want;

    // shadow of the decoder state
    logic [3:0] module_id;
    logic [3:0] byte_pos;
    logic       prefix_ok;
    logic       frame_ok;
    logic [7:0] nn_chars[2];
    logic [1:0] nn_len;
    logic [7:0] val_chars[4];
    logic [7:0] shown_chars[2];
    logic [1:0] shown_len;
    logic [7:0] pins;
    logic       done_flag;

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // atol over the four value characters: accept flag, nonzero through the output
    function automatic logic value_accepts(output logic nonzero);
        int unsigned i;
        logic        neg;
        int unsigned mag;
        i   = 0;
        neg = 1'b0;
        mag = 0;
        while (i < 4 && is_blank(val_chars[i]))
            i++;
        if (i < 4 && (val_chars[i] == CH_PLUS || val_chars[i] == CH_MINUS))
        begin
            neg = (val_chars[i] == CH_MINUS);
            i++;
        end
        while (i < 4 && val_chars[i] >= CH_ZERO && val_chars[i] <= CH_NINE)
        begin
            mag = mag * 10 + 32'(val_chars[i] - CH_ZERO);
            i++;
        end
        nonzero = (mag != 0);
        return neg || mag <= 1;
    endfunction

    // one write byte against the frame, positions past 14 ignored
    task automatic take_write_byte(input logic [7:0] b);
        if (byte_pos == 4'd15)
            return;
        if (byte_pos < 4'd5)
        begin
            if (b != FRAME_HEAD[39 - 8 * byte_pos -: 8])
                prefix_ok = 1'b0;
        end
        else if (byte_pos == 4'd5)
        begin
            if (module_id > 4'd9 || b != CH_ZERO + 8'(module_id))
                prefix_ok = 1'b0;
        end
        else if (byte_pos == 4'd6)
        begin
            if (b != CH_DOT)
                prefix_ok = 1'b0;
        end
        else if (byte_pos <= 4'd8)
        begin
            nn_chars[byte_pos - 4'd7] = b;
            nn_len = 2'(byte_pos - 4'd6);
        end
        else if (byte_pos == 4'd9)
        begin
            if (b != CH_EQ)
                frame_ok = 1'b0;
        end
        else if (byte_pos <= 4'd13)
        begin
            val_chars[byte_pos - 4'd10] = b;
        end
        else
        begin
            if (b != CH_COLON)
                frame_ok = 1'b0;
        end
        byte_pos = byte_pos + 4'd1;
    endtask

    // end of write: commit the number, maybe drive a pin, one result beat
    task automatic finish_write();
        logic        nonzero;
        logic        accepted;
        int unsigned bit_n;
        reply_beat_t r;
        done_flag = 1'b0;
        if (prefix_ok && byte_pos >= 4'd7)
        begin
            shown_chars[0] = nn_chars[0];
            shown_chars[1] = nn_chars[1];
            shown_len      = nn_len;
            if (frame_ok && byte_pos == 4'd15)
            begin
                accepted = value_accepts(nonzero);
                if (nn_chars[0] == CH_ZERO && nn_chars[1] >= CH_ONE
                    && nn_chars[1] <= CH_ZERO + 8'(NUM_OUTPUTS) && accepted)
                begin
                    bit_n     = 32'(nn_chars[1] - CH_ONE);
                    done_flag = 1'b1;
                    if (bit_n < PIN_W)
                        pins[bit_n] = nonzero;
                end
            end
        end
        byte_pos  = 4'd0;
        prefix_ok = 1'b1;
        frame_ok  = 1'b1;
        nn_len    = 2'd0;
        r.text = 8'h00;
        r.last = 1'b1;
        r.pins = pins;
        r.done = done_flag;
        expected_replies.push_back(r);
    endtask

    // read request: "<m>.<NN>.DONE;" or "<m>.<NN>.XXXX;", then done clears
    task automatic emit_reply();
        logic [7:0]  text[$];
        logic        was_done;
        logic [31:0] word;
        reply_beat_t r;
        was_done = done_flag;
        word     = was_done ? WORD_DONE : WORD_FAIL;
        text.push_back(CH_ZERO + 8'(module_id));
        text.push_back(CH_DOT);
        for (int k = 0; k < int'(shown_len) && k < 2; k++)
            text.push_back(shown_chars[k]);
        text.push_back(CH_DOT);
        for (int k = 0; k < 4; k++)
            text.push_back(word[31 - 8 * k -: 8]);
        text.push_back(CH_SEMI);
        done_flag = 1'b0;
        for (int k = 0; k < text.size(); k++)
        begin
            r.text = text[k];
            r.last = (k == text.size() - 1);
            r.pins = pins;
            r.done = was_done;
            expected_replies.push_back(r);
        end
    endtask

    // compare each reply beat first, then predict from the input beat of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_id      = MODULE_ID_RESET;
            byte_pos       = 4'd0;
            prefix_ok      = 1'b1;
            frame_ok       = 1'b1;
            nn_chars[0]    = 8'h00;
            nn_chars[1]    = 8'h00;
            nn_len         = 2'd0;
            for (int k = 0; k < 4; k++)
                val_chars[k] = 8'h00;
            shown_chars[0] = CH_X;
            shown_chars[1] = CH_X;
            shown_len      = 2'd2;
            pins           = '0;
            done_flag      = 1'b0;
            expected_replies.delete();
            mismatches     = 0;
            awaiting       = 0;
            beats_checked  = 0;
        end
        else
        begin
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                beats_checked++;
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected reply beat: reply_byte %h", rsp_mon.reply_byte);
                    mismatches++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (rsp_mon.reply_byte !== want.text)
                    begin
                        $error("reply_byte: expected %h, got %h", want.text, rsp_mon.reply_byte);
                        mismatches++;
                    end
                    if (rsp_mon.reply_last !== want.last)
                    begin
                        $error("reply_last: expected %b, got %b", want.last, rsp_mon.reply_last);
                        mismatches++;
                    end
                    if (rsp_mon.output_pins !== want.pins)
                    begin
                        $error("output_pins: expected %h, got %h", want.pins,
                               rsp_mon.output_pins);
                        mismatches++;
                    end
                    if (rsp_mon.command_done !== want.done)
                    begin
                        $error("command_done: expected %b, got %b", want.done,
                               rsp_mon.command_done);
                        mismatches++;
                    end
                end
            end
            if (cfg_mon.valid && cfg_mon.ready)
                module_id = cfg_mon.module_id;
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                case (cmd_mon.mode)
                    MODE_BYTE: take_write_byte(cmd_mon.data_byte);
                    MODE_END:  finish_write();
                    MODE_READ: emit_reply();
                    default:   ;
                endcase
            end
            awaiting = expected_replies.size();
        end
    end

endmodule

// File: verif/ascii_set_command_output_module_tb.sv
// testbench top for the ascii set command decoder: clock, reset, stimulus, verdict
// drives the input and config channels, stalls the reply channel, checking in ascmd_command_checker
// depends on ascmd_pkg, the three channel interfaces and the decoder rtl
`timescale 1ns / 1ps

module ascii_set_command_output_module_tb
    import ascmd_pkg::*;
;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         PHASE_ITEMS  = 24;
    localparam int         PHASE_COUNT  = 6;
    localparam int         SETTLE_CYCLES = 8;

    logic       clk;
    logic       rst_n;
    int         cycles = 0;
    int         mismatches;
    int         awaiting;
    int         beats_checked;
    int         burst_left;
    logic       calm;
    logic [7:0] stall_pattern;
    logic [3:0] id_now;
    int         items_sent;
    int         reads_sent;
    int         settings_used;
    int         phase_start;

    ascmd_in_if  cmd_in();
    ascmd_out_if rsp_out();
    ascmd_cfg_if cfg();

    ascii_set_command_output_module dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_in (cmd_in),
        .rsp_out(rsp_out),
        .cfg    (cfg)
    );

    ascmd_command_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_mon      (cmd_in),
        .rsp_mon      (rsp_out),
        .cfg_mon      (cfg),
        .mismatches   (mismatches),
        .awaiting     (awaiting),
        .beats_checked(beats_checked)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // reply side stalls on a rotating pattern, reloaded now and then
    always @(negedge clk)
    begin
        rsp_out.ready <= calm ? 1'b1 : stall_pattern[0];
        if ($urandom_range(63) == 0)
            stall_pattern <= 8'($urandom_range(255)) | 8'h01;
        else
            stall_pattern <= {stall_pattern[0], stall_pattern[7:1]};
    end

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_blank();
        return ($urandom_range(2) == 0) ? CH_SPACE : 8'($urandom_range(CH_CR, CH_TAB));
    endfunction

    // one input beat, entered and left at a falling edge; valid stays up between beats of a burst
    task automatic send_beat(input logic [1:0] m, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = calm ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                cmd_in.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(12, 1);
        end
        cmd_in.valid     <= 1'b1;
        cmd_in.mode      <= m;
        cmd_in.data_byte <= b;
        @(posedge clk);
        while (!cmd_in.ready)
            @(posedge clk);
        burst_left--;
        if (m != MODE_UNUSED)
            items_sent++;
        if (m == MODE_READ)
            reads_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(MODE_BYTE, s[i]);
    endtask

    // drop valid and let every expected beat arrive, plus a short settle
    task automatic drain();
        cmd_in.valid <= 1'b0;
        @(negedge clk);
        while (awaiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_module_id(input logic [3:0] v);
        drain();
        cfg.valid     <= 1'b1;
        cfg.module_id <= v;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        id_now = v;
        settings_used++;
    endtask

    // one write message: mostly frames with random content, some cut, long or noise
    task automatic send_message();
        logic [7:0] msg[$];
        int         kind;
        int         cut;
        int         read_at;
        kind = $urandom_range(99);
        if (kind < 15)
        begin
            repeat ($urandom_range(20)) msg.push_back(8'($urandom_range(255)));
        end
        else
        begin
            msg.push_back(CH_SLASH);
            msg.push_back(CH_S);
            msg.push_back(CH_E);
            msg.push_back(CH_T);
            msg.push_back(CH_DOT);
            msg.push_back(($urandom_range(7) == 0) ? rand_digit() : CH_ZERO + 8'(id_now));
            msg.push_back(CH_DOT);
            // output number
            if ($urandom_range(6) != 0)
                msg.push_back(CH_ZERO);
            else
                msg.push_back(($urandom_range(1) == 0) ? CH_ONE : 8'($urandom_range(255)));
            if ($urandom_range(4) != 0)
                msg.push_back(CH_ONE + 8'($urandom_range(NUM_OUTPUTS - 1)));
            else
                case ($urandom_range(2))
                    0:       msg.push_back(CH_ZERO);
                    1:       msg.push_back(CH_NINE);
                    default: msg.push_back(8'($urandom_range(255)));
                endcase
            msg.push_back(CH_EQ);
            // value text
            case ($urandom_range(5))
                0:
                begin
                    repeat (3) msg.push_back(CH_ZERO);
                    msg.push_back(CH_ZERO + 8'($urandom_range(1)));
                end
                1:
                begin
                    msg.push_back(rand_blank());
                    msg.push_back(rand_blank());
                    case ($urandom_range(2))
                        0:       msg.push_back(CH_PLUS);
                        1:       msg.push_back(CH_MINUS);
                        default: msg.push_back(rand_digit());
                    endcase
                    msg.push_back(($urandom_range(1) == 0) ? CH_ONE : rand_digit());
                end
                2:
                begin
                    msg.push_back(CH_MINUS);
                    repeat (3) msg.push_back(rand_digit());
                end
                3:
                begin
                    repeat (4) msg.push_back(rand_digit());
                end
                4:
                begin
                    msg.push_back(CH_ZERO + 8'($urandom_range(1)));
                    repeat (3) msg.push_back(8'($urandom_range(255)));
                end
                default:
                begin
                    repeat (4) msg.push_back(8'($urandom_range(255)));
                end
            endcase
            msg.push_back(CH_COLON);
            if (kind < 30)
            begin
                cut = $urandom_range(14);
                while (msg.size() > cut)
                    void'(msg.pop_back());
            end
            else if ($urandom_range(4) == 0)
            begin
                repeat ($urandom_range(6, 1)) msg.push_back(8'($urandom_range(255)));
            end
            else if ($urandom_range(5) == 0)
            begin
                msg[$urandom_range(14)] = 8'($urandom_range(255));
            end
        end
        // occasional read in the middle of the write
        read_at = ($urandom_range(7) == 0) ? int'($urandom_range(msg.size())) : -1;
        for (int i = 0; i <= msg.size(); i++)
        begin
            if (i == read_at)
                send_beat(MODE_READ, 8'($urandom_range(255)));
            if (i < msg.size())
                send_beat(MODE_BYTE, msg[i]);
        end
        send_beat(MODE_END, 8'($urandom_range(255)));
        if ($urandom_range(9) < 6)
            send_beat(MODE_READ, 8'($urandom_range(255)));
        if ($urandom_range(15) == 0)
            send_beat(MODE_UNUSED, 8'($urandom_range(255)));
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cmd_in.valid     = 1'b0;
        cmd_in.mode      = MODE_BYTE;
        cmd_in.data_byte = 8'h00;
        cfg.valid        = 1'b0;
        cfg.module_id    = MODULE_ID_RESET;
        rsp_out.ready    = 1'b0;
        stall_pattern    = 8'hB5;
        calm             = 1'b0;
        burst_left       = 0;
        id_now           = MODULE_ID_RESET;
        items_sent       = 0;
        reads_sent       = 0;
        settings_used    = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // accepted command on output 08, with a read in the middle of the frame
        send_text("/SET.1.0");
        send_beat(MODE_READ, 8'h00);
        send_text("8= +01:");
        send_beat(MODE_END, 8'hFF);
        // done reported once, then cleared
        send_beat(MODE_READ, 8'hFF);
        send_beat(MODE_READ, 8'h00);
        // ignored mode
        send_beat(MODE_UNUSED, 8'hFF);
        // short message leaves the shown number unchanged
        send_text("/S");
        send_beat(MODE_END, 8'h00);
        send_beat(MODE_READ, 8'h5A);

        // random phases over module ids, extremes and above nine included
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:       write_module_id(4'd0);
                1:       write_module_id(4'd9);
                2:       write_module_id(4'd15);
                3:       write_module_id(4'($urandom_range(8, 2)));
                4:       write_module_id(4'($urandom_range(14, 10)));
                default: write_module_id(MODULE_ID_RESET);
            endcase
            calm = (p == 3);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_message();
        end
        calm = 1'b0;

        drain();
        $display("sent %0d input beats (%0d reads) over %0d module id settings",
                 items_sent, reads_sent, settings_used);
        $display("checked %0d reply beats against the prediction", beats_checked);
        if (mismatches == 0 && awaiting == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/ascmd_pkg.sv
design/ascmd_in_if.sv
design/ascmd_out_if.sv
design/ascmd_cfg_if.sv
design/ascmd_ctrl.sv
design/ascmd_dp.sv
design/ascii_set_command_output_module.sv
design/ascmd_checker.sv
verif/ascmd_command_checker.sv
verif/ascii_set_command_output_module_tb.sv
